>>> rtl/assert_macros.svh
// Assertion helpers for the RTL files.
// Every macro samples on the rising edge of clk and is off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define PEQ_ASSERT_ALWAYS(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define PEQ_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PEQ_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/peq_pkg.sv
// ----------------------------------------------------------------------------
// peq_pkg
// Types, constants and helper functions of the process entry pool block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package peq_pkg;

	localparam int NUM_ENTRIES = 32;
	localparam int IDX_W       = 6;
	localparam int ADDR_W      = $clog2(NUM_ENTRIES);
	localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
	localparam int OP_W        = 4;
	localparam int PAR_W       = 5;

	// Index value that means no entry.
	localparam logic [IDX_W-1:0] NONE = IDX_W'(NUM_ENTRIES);

	// Link stores.
	localparam int ST_QN      = 0;
	localparam int ST_QP      = 1;
	localparam int ST_PAR     = 2;
	localparam int ST_FC      = 3;
	localparam int ST_SN      = 4;
	localparam int ST_SP      = 5;
	localparam int NUM_STORES = 6;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 4'd0,
		OP_FREE    = 4'd1,
		OP_ENQ     = 4'd2,
		OP_DEQ     = 4'd3,
		OP_REMOVE  = 4'd4,
		OP_HEAD    = 4'd5,
		OP_ADD_CH  = 4'd6,
		OP_REM_FC  = 4'd7,
		OP_DETACH  = 4'd8
	} peq_op_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] queue_tail;
		logic [IDX_W-1:0] entry;
		logic [PAR_W-1:0] parent_entry;
	} peq_cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] result_entry;
		logic [IDX_W-1:0] new_tail;
	} peq_rsp_t;

	// Read and write request to a link store.
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		logic [IDX_W-1:0] wr_data;
	} peq_req_t;

	// Value an entry holds before its first write.
	typedef enum logic [1:0] {
		INIT_NONE = 2'd0,
		INIT_INC  = 2'd1,
		INIT_DEC  = 2'd2
	} peq_init_t;

	function automatic logic [IDX_W-1:0] norm_idx(input logic [IDX_W-1:0] v);
		return (v < NONE) ? v : NONE;
	endfunction

	function automatic logic [IDX_W-1:0] init_link(input peq_init_t mode,
			input logic [ADDR_W-1:0] addr);
		logic [IDX_W-1:0] v;
		v = NONE;
		case (mode)
			INIT_INC: v = (addr == ADDR_W'(NUM_ENTRIES - 1)) ? '0
				: IDX_W'(addr) + IDX_W'(1);
			INIT_DEC: v = (addr == '0) ? IDX_W'(NUM_ENTRIES - 1)
				: IDX_W'(addr) - IDX_W'(1);
			default: v = NONE;
		endcase
		return v;
	endfunction

	function automatic peq_init_t store_mode(input int i);
		peq_init_t m;
		m = INIT_NONE;
		if (i == ST_QN) m = INIT_INC;
		if (i == ST_QP) m = INIT_DEC;
		return m;
	endfunction

	function automatic peq_req_t idle_req();
		peq_req_t r;
		r = '0;
		return r;
	endfunction

	function automatic peq_req_t rd_req(input logic [IDX_W-1:0] idx);
		peq_req_t r;
		r        = '0;
		r.rd_en  = 1'b1;
		r.rd_idx = idx;
		return r;
	endfunction

	function automatic peq_req_t wr_req(input logic [IDX_W-1:0] idx,
			input logic [IDX_W-1:0] data);
		peq_req_t r;
		r         = '0;
		r.wr_en   = 1'b1;
		r.wr_idx  = idx;
		r.wr_data = data;
		return r;
	endfunction

endpackage

>>> rtl/peq_ram.sv
// ----------------------------------------------------------------------------
// peq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module peq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/peq_store.sv
// ----------------------------------------------------------------------------
// peq_store
// One link array: a RAM with per-entry valid bits that stand in for the reset
// value, range checks on the index and write-to-read forwarding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module peq_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  peq_pkg::peq_init_t            mode,
	input  peq_pkg::peq_req_t             req,
	output logic [peq_pkg::IDX_W-1:0]     rdata
);

	logic [peq_pkg::NUM_ENTRIES-1:0] valid_q;
	logic                            wr_ok;
	logic                            rd_ok;
	logic [peq_pkg::ADDR_W-1:0]      waddr;
	logic [peq_pkg::ADDR_W-1:0]      raddr;
	logic [peq_pkg::IDX_W-1:0]       ram_q;
	logic                            oob_s1;
	logic                            fwd_s1;
	logic                            vld_s1;
	logic [peq_pkg::ADDR_W-1:0]      addr_s1;
	logic [peq_pkg::IDX_W-1:0]       fwd_data_s1;

	// Indexes at or above the pool size mean no entry.
	assign wr_ok = req.wr_en && (req.wr_idx < peq_pkg::NONE);
	assign rd_ok = req.rd_idx < peq_pkg::NONE;
	assign waddr = req.wr_idx[peq_pkg::ADDR_W-1:0];
	assign raddr = req.rd_idx[peq_pkg::ADDR_W-1:0];

	peq_ram #(
		.WIDTH (peq_pkg::IDX_W),
		.DEPTH (peq_pkg::NUM_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (wr_ok),
		.waddr (waddr),
		.wdata (req.wr_data),
		.re    (req.rd_en && rd_ok),
		.raddr (raddr),
		.rdata (ram_q)
	);

	// An entry reads its reset value until its first write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_ok) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// Read side flags, kept until the next read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oob_s1 <= 1'b1;
			fwd_s1 <= 1'b0;
			vld_s1 <= 1'b0;
		end else if (req.rd_en) begin
			oob_s1 <= !rd_ok;
			fwd_s1 <= rd_ok && wr_ok && (req.wr_idx == req.rd_idx);
			vld_s1 <= rd_ok && valid_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			addr_s1     <= raddr;
			fwd_data_s1 <= req.wr_data;
		end
	end

	// Read data selection.
	always_comb begin
		if (oob_s1) begin
			rdata = peq_pkg::NONE;
		end else if (fwd_s1) begin
			rdata = fwd_data_s1;
		end else if (vld_s1) begin
			rdata = ram_q;
		end else begin
			rdata = peq_pkg::init_link(mode, addr_s1);
		end
	end

endmodule

>>> rtl/process_entry_pool_queue_tree_unit.sv
// ----------------------------------------------------------------------------
// process_entry_pool_queue_tree_unit
// Pool of process entries with a free list, caller-held circular queues and a
// child tree, all kept as link arrays in six small RAMs.
// ----------------------------------------------------------------------------
// Usage:
// A command beat is taken when start is high and busy is low; cmd carries
// op, queue_tail, entry and parent_entry. Exactly one result beat follows on
// rsp, marked by done for a single cycle; the receiver cannot stall it, so
// it must take the beat in that cycle. busy stays high from the cycle after
// the command until done shows, and a new command may be given in the
// cycle done is high.
// Commands settled at decode (an operand that names no entry, an unknown
// op, insertion into an empty queue) finish from S_DEC; the others go
// on through further states, and remove given walks the queue one link
// per cycle. The pace is set by the dependent link reads, each a
// registered RAM read, done one at a time.
// Reset puts all entries on the free list and clears the child tree at
// once through per-entry valid bits; a command may follow right away.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module process_entry_pool_queue_tree_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  peq_pkg::peq_cmd_t cmd,
	output logic              done,
	output peq_pkg::peq_rsp_t rsp
);

	localparam int IW = peq_pkg::IDX_W;

	typedef enum logic [19:0] {
		S_IDLE = 20'h00001,
		S_DEC  = 20'h00002,
		S_RH1  = 20'h00004,
		S_RH2  = 20'h00008,
		S_RH3  = 20'h00010,
		S_INS1 = 20'h00020,
		S_INS2 = 20'h00040,
		S_RG1  = 20'h00080,
		S_RG2  = 20'h00100,
		S_RG3  = 20'h00200,
		S_HD1  = 20'h00400,
		S_AC1  = 20'h00800,
		S_AC2  = 20'h01000,
		S_RF1  = 20'h02000,
		S_RF2  = 20'h04000,
		S_RF3  = 20'h08000,
		S_DT1  = 20'h10000,
		S_DT2  = 20'h20000,
		S_DT3  = 20'h40000,
		S_DT4  = 20'h80000
	} state_t;

	state_t                      state_q, state_d;
	peq_pkg::peq_op_t            op_q, op_d;
	logic [IW-1:0]               qt_q, qt_d;
	logic [IW-1:0]               wt_q, wt_d;
	logic [IW-1:0]               ent_q, ent_d;
	logic [IW-1:0]               par_q, par_d;
	logic [IW-1:0]               head_q, head_d;
	logic [IW-1:0]               ft_q, ft_d;
	logic [peq_pkg::CNT_W-1:0]   cnt_q, cnt_d;
	logic                        done_q;
	peq_pkg::peq_rsp_t           rsp_q;
	logic                        fin;
	logic [IW-1:0]               res_d;
	logic [IW-1:0]               ntail_d;
	logic [IW-1:0]               wt_in;
	logic                        is_alloc;
	logic                        found;
	peq_pkg::peq_req_t           req [peq_pkg::NUM_STORES];
	logic [IW-1:0]               rdata [peq_pkg::NUM_STORES];

	// Link stores.
	for (genvar g = 0; g < peq_pkg::NUM_STORES; g++) begin : g_store
		peq_store u_store (
			.clk    (clk),
			.arst_n (arst_n),
			.mode   (peq_pkg::store_mode(g)),
			.req    (req[g]),
			.rdata  (rdata[g])
		);
	end

	assign is_alloc = (op_q == peq_pkg::OP_ALLOC);
	assign wt_in    = (is_alloc || op_q == peq_pkg::OP_FREE) ? ft_q : qt_q;

	// Sequencer: each state does some of: issue reads, consume the previous read, write.
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		qt_d    = qt_q;
		wt_d    = wt_q;
		ent_d   = ent_q;
		par_d   = par_q;
		head_d  = head_q;
		ft_d    = ft_q;
		cnt_d   = cnt_q;
		fin     = 1'b0;
		found   = 1'b0;
		res_d   = peq_pkg::NONE;
		ntail_d = qt_q;
		for (int k = 0; k < peq_pkg::NUM_STORES; k++) begin
			req[k] = peq_pkg::idle_req();
		end

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op_d    = peq_pkg::peq_op_t'(cmd.op);
					qt_d    = peq_pkg::norm_idx(cmd.queue_tail);
					ent_d   = peq_pkg::norm_idx(cmd.entry);
					par_d   = IW'(cmd.parent_entry);
					state_d = S_DEC;
				end
			end

			S_DEC: begin
				state_d = S_IDLE;
				unique case (op_q) inside
					peq_pkg::OP_ALLOC, peq_pkg::OP_DEQ: begin
						if (wt_in >= peq_pkg::NONE) begin
							fin = 1'b1;
						end else begin
							req[peq_pkg::ST_QN] = peq_pkg::rd_req(wt_in);
							wt_d    = wt_in;
							state_d = S_RH1;
						end
					end
					peq_pkg::OP_FREE, peq_pkg::OP_ENQ: begin
						if (ent_q >= peq_pkg::NONE) begin
							fin = 1'b1;
						end else if (wt_in >= peq_pkg::NONE) begin
							// Insert into an empty queue: the entry links to itself.
							req[peq_pkg::ST_QN] = peq_pkg::wr_req(ent_q, ent_q);
							req[peq_pkg::ST_QP] = peq_pkg::wr_req(ent_q, ent_q);
							fin   = 1'b1;
							res_d = ent_q;
							if (op_q == peq_pkg::OP_FREE) begin
								ft_d = ent_q;
							end else begin
								ntail_d = ent_q;
							end
						end else begin
							req[peq_pkg::ST_QN] = peq_pkg::rd_req(wt_in);
							wt_d    = wt_in;
							state_d = S_INS1;
						end
					end
					peq_pkg::OP_REMOVE: begin
						if (qt_q >= peq_pkg::NONE || ent_q >= peq_pkg::NONE) begin
							fin = 1'b1;
						end else begin
							req[peq_pkg::ST_QN] = peq_pkg::rd_req(qt_q);
							cnt_d   = '0;
							state_d = S_RG1;
						end
					end
					peq_pkg::OP_HEAD: begin
						if (qt_q >= peq_pkg::NONE) begin
							fin = 1'b1;
						end else begin
							req[peq_pkg::ST_QN] = peq_pkg::rd_req(qt_q);
							state_d = S_HD1;
						end
					end
					peq_pkg::OP_ADD_CH: begin
						if (ent_q >= peq_pkg::NONE || par_q >= peq_pkg::NONE) begin
							fin = 1'b1;
						end else begin
							req[peq_pkg::ST_FC] = peq_pkg::rd_req(par_q);
							state_d = S_AC1;
						end
					end
					peq_pkg::OP_REM_FC: begin
						if (ent_q >= peq_pkg::NONE) begin
							fin = 1'b1;
						end else begin
							req[peq_pkg::ST_FC] = peq_pkg::rd_req(ent_q);
							par_d   = ent_q;
							state_d = S_RF1;
						end
					end
					peq_pkg::OP_DETACH: begin
						if (ent_q >= peq_pkg::NONE) begin
							fin = 1'b1;
						end else begin
							req[peq_pkg::ST_PAR] = peq_pkg::rd_req(ent_q);
							state_d = S_DT1;
						end
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end

			// Remove head: the head is the tail's next link.
			S_RH1: begin
				if (rdata[peq_pkg::ST_QN] == wt_q || rdata[peq_pkg::ST_QN] >= peq_pkg::NONE) begin
					req[peq_pkg::ST_QN] = peq_pkg::wr_req(wt_q, peq_pkg::NONE);
					req[peq_pkg::ST_QP] = peq_pkg::wr_req(wt_q, peq_pkg::NONE);
					if (is_alloc) begin
						req[peq_pkg::ST_PAR] = peq_pkg::wr_req(wt_q, peq_pkg::NONE);
						req[peq_pkg::ST_FC]  = peq_pkg::wr_req(wt_q, peq_pkg::NONE);
						req[peq_pkg::ST_SN]  = peq_pkg::wr_req(wt_q, peq_pkg::NONE);
						req[peq_pkg::ST_SP]  = peq_pkg::wr_req(wt_q, peq_pkg::NONE);
						ft_d = peq_pkg::NONE;
					end else begin
						ntail_d = peq_pkg::NONE;
					end
					fin     = 1'b1;
					res_d   = wt_q;
					state_d = S_IDLE;
				end else begin
					head_d  = rdata[peq_pkg::ST_QN];
					req[peq_pkg::ST_QN] = peq_pkg::rd_req(rdata[peq_pkg::ST_QN]);
					state_d = S_RH2;
				end
			end

			S_RH2: begin
				req[peq_pkg::ST_QN] = peq_pkg::wr_req(wt_q, rdata[peq_pkg::ST_QN]);
				req[peq_pkg::ST_QP] = peq_pkg::wr_req(rdata[peq_pkg::ST_QN], wt_q);
				state_d = S_RH3;
			end

			S_RH3: begin
				req[peq_pkg::ST_QN] = peq_pkg::wr_req(head_q, peq_pkg::NONE);
				req[peq_pkg::ST_QP] = peq_pkg::wr_req(head_q, peq_pkg::NONE);
				if (is_alloc) begin
					req[peq_pkg::ST_PAR] = peq_pkg::wr_req(head_q, peq_pkg::NONE);
					req[peq_pkg::ST_FC]  = peq_pkg::wr_req(head_q, peq_pkg::NONE);
					req[peq_pkg::ST_SN]  = peq_pkg::wr_req(head_q, peq_pkg::NONE);
					req[peq_pkg::ST_SP]  = peq_pkg::wr_req(head_q, peq_pkg::NONE);
				end else begin
					ntail_d = wt_q;
				end
				fin     = 1'b1;
				res_d   = head_q;
				state_d = S_IDLE;
			end

			// Insert at tail of a non-empty queue.
			S_INS1: begin
				head_d  = rdata[peq_pkg::ST_QN];
				req[peq_pkg::ST_QN] = peq_pkg::wr_req(wt_q, ent_q);
				req[peq_pkg::ST_QP] = peq_pkg::wr_req(ent_q, wt_q);
				state_d = S_INS2;
			end

			S_INS2: begin
				req[peq_pkg::ST_QN] = peq_pkg::wr_req(ent_q, head_q);
				req[peq_pkg::ST_QP] = peq_pkg::wr_req(head_q, ent_q);
				fin   = 1'b1;
				res_d = ent_q;
				if (op_q == peq_pkg::OP_FREE) begin
					ft_d = ent_q;
				end else begin
					ntail_d = ent_q;
				end
				state_d = S_IDLE;
			end

			// Walk the queue one link a cycle looking for the entry.
			S_RG1: begin
				if (cnt_q < peq_pkg::CNT_W'(peq_pkg::NUM_ENTRIES)
						&& rdata[peq_pkg::ST_QN] < peq_pkg::NONE) begin
					if (rdata[peq_pkg::ST_QN] == ent_q) begin
						found = 1'b1;
					end else if (rdata[peq_pkg::ST_QN] == qt_q) begin
						fin     = 1'b1;
						state_d = S_IDLE;
					end else begin
						req[peq_pkg::ST_QN] = peq_pkg::rd_req(rdata[peq_pkg::ST_QN]);
						cnt_d = cnt_q + peq_pkg::CNT_W'(1);
					end
				end else if (rdata[peq_pkg::ST_QN] == ent_q) begin
					found = 1'b1;
				end else begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end
				if (found) begin
					req[peq_pkg::ST_QN] = peq_pkg::rd_req(ent_q);
					req[peq_pkg::ST_QP] = peq_pkg::rd_req(ent_q);
					state_d = S_RG2;
				end
			end

			S_RG2: begin
				if (rdata[peq_pkg::ST_QN] == ent_q || rdata[peq_pkg::ST_QN] >= peq_pkg::NONE
						|| rdata[peq_pkg::ST_QP] >= peq_pkg::NONE) begin
					wt_d = peq_pkg::NONE;
				end else begin
					req[peq_pkg::ST_QN] = peq_pkg::wr_req(rdata[peq_pkg::ST_QP],
						rdata[peq_pkg::ST_QN]);
					req[peq_pkg::ST_QP] = peq_pkg::wr_req(rdata[peq_pkg::ST_QN],
						rdata[peq_pkg::ST_QP]);
					wt_d = (ent_q == qt_q) ? rdata[peq_pkg::ST_QP] : qt_q;
				end
				state_d = S_RG3;
			end

			S_RG3: begin
				req[peq_pkg::ST_QN] = peq_pkg::wr_req(ent_q, peq_pkg::NONE);
				req[peq_pkg::ST_QP] = peq_pkg::wr_req(ent_q, peq_pkg::NONE);
				fin     = 1'b1;
				res_d   = ent_q;
				ntail_d = wt_q;
				state_d = S_IDLE;
			end

			S_HD1: begin
				fin     = 1'b1;
				res_d   = rdata[peq_pkg::ST_QN];
				state_d = S_IDLE;
			end

			// Add child: the new child goes in front of the old first child.
			S_AC1: begin
				head_d = rdata[peq_pkg::ST_FC];
				req[peq_pkg::ST_SN]  = peq_pkg::wr_req(ent_q, rdata[peq_pkg::ST_FC]);
				req[peq_pkg::ST_SP]  = peq_pkg::wr_req(ent_q, peq_pkg::NONE);
				req[peq_pkg::ST_FC]  = peq_pkg::wr_req(par_q, ent_q);
				req[peq_pkg::ST_PAR] = peq_pkg::wr_req(ent_q, par_q);
				state_d = S_AC2;
			end

			S_AC2: begin
				req[peq_pkg::ST_SP] = peq_pkg::wr_req(head_q, ent_q);
				fin     = 1'b1;
				res_d   = ent_q;
				state_d = S_IDLE;
			end

			// Remove first child of par_q.
			S_RF1: begin
				if (rdata[peq_pkg::ST_FC] >= peq_pkg::NONE) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					head_d  = rdata[peq_pkg::ST_FC];
					req[peq_pkg::ST_SN] = peq_pkg::rd_req(rdata[peq_pkg::ST_FC]);
					state_d = S_RF2;
				end
			end

			S_RF2: begin
				req[peq_pkg::ST_FC]  = peq_pkg::wr_req(par_q, rdata[peq_pkg::ST_SN]);
				req[peq_pkg::ST_SP]  = peq_pkg::wr_req(rdata[peq_pkg::ST_SN], peq_pkg::NONE);
				req[peq_pkg::ST_PAR] = peq_pkg::wr_req(head_q, peq_pkg::NONE);
				req[peq_pkg::ST_SN]  = peq_pkg::wr_req(head_q, peq_pkg::NONE);
				state_d = S_RF3;
			end

			S_RF3: begin
				req[peq_pkg::ST_SP] = peq_pkg::wr_req(head_q, peq_pkg::NONE);
				fin     = 1'b1;
				res_d   = head_q;
				state_d = S_IDLE;
			end

			// Detach: a first child goes through the remove first child path.
			S_DT1: begin
				if (rdata[peq_pkg::ST_PAR] >= peq_pkg::NONE) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					par_d   = rdata[peq_pkg::ST_PAR];
					req[peq_pkg::ST_FC] = peq_pkg::rd_req(rdata[peq_pkg::ST_PAR]);
					state_d = S_DT2;
				end
			end

			S_DT2: begin
				req[peq_pkg::ST_SN] = peq_pkg::rd_req(ent_q);
				if (rdata[peq_pkg::ST_FC] == ent_q) begin
					head_d  = ent_q;
					state_d = S_RF2;
				end else begin
					req[peq_pkg::ST_SP] = peq_pkg::rd_req(ent_q);
					state_d = S_DT3;
				end
			end

			S_DT3: begin
				req[peq_pkg::ST_SN]  = peq_pkg::wr_req(rdata[peq_pkg::ST_SP],
					rdata[peq_pkg::ST_SN]);
				req[peq_pkg::ST_SP]  = peq_pkg::wr_req(rdata[peq_pkg::ST_SN],
					rdata[peq_pkg::ST_SP]);
				req[peq_pkg::ST_PAR] = peq_pkg::wr_req(ent_q, peq_pkg::NONE);
				state_d = S_DT4;
			end

			S_DT4: begin
				req[peq_pkg::ST_SN] = peq_pkg::wr_req(ent_q, peq_pkg::NONE);
				req[peq_pkg::ST_SP] = peq_pkg::wr_req(ent_q, peq_pkg::NONE);
				fin     = 1'b1;
				res_d   = ent_q;
				state_d = S_IDLE;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= peq_pkg::OP_ALLOC;
			ft_q    <= IW'(peq_pkg::NUM_ENTRIES - 1);
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			ft_q    <= ft_d;
			cnt_q   <= cnt_d;
			done_q  <= fin;
		end
	end

	// Working registers and the result beat.
	always_ff @(posedge clk) begin
		qt_q   <= qt_d;
		wt_q   <= wt_d;
		ent_q  <= ent_d;
		par_q  <= par_d;
		head_q <= head_d;
		if (fin) begin
			rsp_q.result_entry <= res_d;
			rsp_q.new_tail     <= ntail_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// Checks.
	`PEQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "command beat did not raise busy")
	`PEQ_ASSERT_IMPL(a_done_idle, done, !busy, "result beat while still busy")
	`PEQ_ASSERT_NEXT(a_done_single, done, !done, "two result beats back to back")
	`PEQ_ASSERT_IMPL(a_rsp_range, done,
		rsp.result_entry <= peq_pkg::NONE && rsp.new_tail <= peq_pkg::NONE,
		"result index out of range")
	`PEQ_ASSERT_ALWAYS(a_free_tail, ft_q <= peq_pkg::NONE, "free list tail out of range")

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the process entry pool block against a built-in predictor of its
// free list, caller-held queues and child tree. Commands go in through a
// start/busy driver fed from a queue; every done beat is compared with the
// oldest predicted response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int N      = peq_pkg::NUM_ENTRIES;
	localparam int IDX_W  = peq_pkg::IDX_W;
	localparam int ADDR_W = peq_pkg::ADDR_W;
	localparam int OP_W   = peq_pkg::OP_W;
	localparam int PAR_W  = peq_pkg::PAR_W;
	localparam logic [IDX_W-1:0] NIL = peq_pkg::NONE;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	peq_pkg::peq_cmd_t cmd;
	logic              done;
	peq_pkg::peq_rsp_t rsp;

	process_entry_pool_queue_tree_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .rsp(rsp)
	);

	// Predictor state of the pool.
	logic [IDX_W-1:0] m_qnext [N];
	logic [IDX_W-1:0] m_qprev [N];
	logic [IDX_W-1:0] m_parent[N];
	logic [IDX_W-1:0] m_fchild[N];
	logic [IDX_W-1:0] m_snext [N];
	logic [IDX_W-1:0] m_sprev [N];
	logic [IDX_W-1:0] m_free_tail;

	peq_pkg::peq_cmd_t pending_cmds[$];
	peq_pkg::peq_rsp_t expected_rsps[$];
	int                errors = 0;
	bit                stim_done = 1'b0;
	int                send_gap = 0;
	logic              beat_taken;

	// Tails of the queues that the stimulus keeps.
	logic [IDX_W-1:0] user_tail[4];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [IDX_W-1:0] nrm(input logic [IDX_W-1:0] v);
		return (v < NIL) ? v : NIL;
	endfunction

	function automatic logic [IDX_W-1:0] rd_link(ref logic [IDX_W-1:0] a[N],
			input logic [IDX_W-1:0] i);
		return (i < NIL) ? nrm(a[i[ADDR_W-1:0]]) : NIL;
	endfunction

	function automatic void wr_link(ref logic [IDX_W-1:0] a[N],
			input logic [IDX_W-1:0] i, input logic [IDX_W-1:0] v);
		if (i < NIL) a[i[ADDR_W-1:0]] = nrm(v);
	endfunction

	function automatic void pool_reset();
		for (int i = 0; i < N; i++) begin
			m_qnext[i]  = IDX_W'((i + 1) % N);
			m_qprev[i]  = IDX_W'((i + N - 1) % N);
			m_parent[i] = NIL;
			m_fchild[i] = NIL;
			m_snext[i]  = NIL;
			m_sprev[i]  = NIL;
		end
		m_free_tail = IDX_W'(N - 1);
	endfunction

	function automatic logic [IDX_W-1:0] link_in(input logic [IDX_W-1:0] t,
			input logic [IDX_W-1:0] p);
		logic [IDX_W-1:0] h;
		if (p >= NIL) return t;
		if (t >= NIL) begin
			wr_link(m_qnext, p, p);
			wr_link(m_qprev, p, p);
			return p;
		end
		h = rd_link(m_qnext, t);
		wr_link(m_qnext, t, p);
		wr_link(m_qprev, p, t);
		wr_link(m_qnext, p, h);
		wr_link(m_qprev, h, p);
		return p;
	endfunction

	function automatic logic [IDX_W-1:0] take_head(inout logic [IDX_W-1:0] t);
		logic [IDX_W-1:0] h, nh;
		if (t >= NIL) return NIL;
		h = rd_link(m_qnext, t);
		if (h == t || h >= NIL) begin
			wr_link(m_qnext, t, NIL);
			wr_link(m_qprev, t, NIL);
			h = t;
			t = NIL;
			return h;
		end
		nh = rd_link(m_qnext, h);
		wr_link(m_qnext, t, nh);
		wr_link(m_qprev, nh, t);
		wr_link(m_qnext, h, NIL);
		wr_link(m_qprev, h, NIL);
		return h;
	endfunction

	function automatic logic [IDX_W-1:0] take_given(inout logic [IDX_W-1:0] t,
			input logic [IDX_W-1:0] p);
		logic [IDX_W-1:0] cur, fw, bw;
		if (t >= NIL || p >= NIL) return NIL;
		cur = rd_link(m_qnext, t);
		for (int i = 0; i < N && cur < NIL; i++) begin
			if (cur == p) break;
			if (cur == t) return NIL;
			cur = rd_link(m_qnext, cur);
		end
		if (cur != p) return NIL;
		fw = rd_link(m_qnext, p);
		bw = rd_link(m_qprev, p);
		if (fw == p || fw >= NIL || bw >= NIL) begin
			t = NIL;
		end else begin
			wr_link(m_qnext, bw, fw);
			wr_link(m_qprev, fw, bw);
			if (p == t) t = bw;
		end
		wr_link(m_qnext, p, NIL);
		wr_link(m_qprev, p, NIL);
		return p;
	endfunction

	function automatic logic [IDX_W-1:0] drop_first_child(input logic [IDX_W-1:0] par);
		logic [IDX_W-1:0] c, nx;
		if (par >= NIL) return NIL;
		c = rd_link(m_fchild, par);
		if (c >= NIL) return NIL;
		nx = rd_link(m_snext, c);
		wr_link(m_fchild, par, nx);
		wr_link(m_sprev, nx, NIL);
		wr_link(m_parent, c, NIL);
		wr_link(m_snext, c, NIL);
		wr_link(m_sprev, c, NIL);
		return c;
	endfunction

	function automatic logic [IDX_W-1:0] detach_child(input logic [IDX_W-1:0] p);
		logic [IDX_W-1:0] par, pv, nx;
		if (p >= NIL) return NIL;
		par = rd_link(m_parent, p);
		if (par >= NIL) return NIL;
		if (rd_link(m_fchild, par) == p) return drop_first_child(par);
		pv = rd_link(m_sprev, p);
		nx = rd_link(m_snext, p);
		wr_link(m_snext, pv, nx);
		wr_link(m_sprev, nx, pv);
		wr_link(m_parent, p, NIL);
		wr_link(m_snext, p, NIL);
		wr_link(m_sprev, p, NIL);
		return p;
	endfunction

	// Applies one command to the predictor and returns its response.
	function automatic peq_pkg::peq_rsp_t pool_apply(input peq_pkg::peq_cmd_t c);
		peq_pkg::peq_rsp_t r;
		logic [IDX_W-1:0] t, p, par, res, ft, old;
		t   = nrm(c.queue_tail);
		p   = nrm(c.entry);
		par = nrm({1'b0, c.parent_entry});
		res = NIL;
		ft  = nrm(m_free_tail);
		case (c.op)
			peq_pkg::OP_ALLOC: begin
				res = take_head(ft);
				m_free_tail = ft;
				if (res < NIL) begin
					wr_link(m_qnext, res, NIL);
					wr_link(m_qprev, res, NIL);
					wr_link(m_parent, res, NIL);
					wr_link(m_fchild, res, NIL);
					wr_link(m_snext, res, NIL);
					wr_link(m_sprev, res, NIL);
				end
			end
			peq_pkg::OP_FREE: if (p < NIL) begin
				m_free_tail = link_in(ft, p);
				res = p;
			end
			peq_pkg::OP_ENQ: if (p < NIL) begin
				t = link_in(t, p);
				res = p;
			end
			peq_pkg::OP_DEQ:    res = take_head(t);
			peq_pkg::OP_REMOVE: res = take_given(t, p);
			peq_pkg::OP_HEAD:   if (t < NIL) res = rd_link(m_qnext, t);
			peq_pkg::OP_ADD_CH: if (p < NIL && par < NIL) begin
				old = rd_link(m_fchild, par);
				wr_link(m_snext, p, old);
				wr_link(m_sprev, p, NIL);
				wr_link(m_sprev, old, p);
				wr_link(m_fchild, par, p);
				wr_link(m_parent, p, par);
				res = p;
			end
			peq_pkg::OP_REM_FC: res = drop_first_child(p);
			peq_pkg::OP_DETACH: res = detach_child(p);
			default: ;
		endcase
		r.result_entry = res;
		r.new_tail     = t;
		return r;
	endfunction

	// Queues a command for the driver together with its predicted response.
	function automatic peq_pkg::peq_rsp_t send_cmd(input peq_pkg::peq_cmd_t c);
		peq_pkg::peq_rsp_t r;
		r = pool_apply(c);
		pending_cmds.push_back(c);
		expected_rsps.push_back(r);
		return r;
	endfunction

	function automatic peq_pkg::peq_cmd_t make_cmd(input logic [OP_W-1:0] op,
			input logic [IDX_W-1:0] t, input logic [IDX_W-1:0] e,
			input logic [PAR_W-1:0] pe);
		peq_pkg::peq_cmd_t c;
		c.op = op;
		c.queue_tail = t;
		c.entry = e;
		c.parent_entry = pe;
		return c;
	endfunction

	function automatic logic [IDX_W-1:0] pick_idx();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return NIL;
		if (r == 1) return IDX_W'($urandom_range(33, 63));
		return IDX_W'($urandom_range(0, N - 1));
	endfunction

	// Records whether a command beat was taken at each rising edge.
	always @(posedge clk) begin
		beat_taken <= arst_n && start && !busy;
	end

	// Driver: presents commands at the falling edge, with random gaps only
	// while more than 60 commands are pending.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd   <= '0;
		end else if (start && beat_taken) begin
			// The beat was taken at the last rising edge.
			if (pending_cmds.size() > 0 && send_gap == 0) begin
				cmd <= pending_cmds.pop_front();
			end else begin
				start <= 1'b0;
			end
			if (pending_cmds.size() > 60 && $urandom_range(0, 5) == 0)
				send_gap = $urandom_range(1, 5);
		end else if (!start) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (pending_cmds.size() > 0) begin
				cmd   <= pending_cmds.pop_front();
				start <= 1'b1;
			end
		end
	end

	// Monitor: compares each done beat with the oldest prediction.
	always @(posedge clk) begin
		peq_pkg::peq_rsp_t want;
		if (arst_n && done) begin
			if (expected_rsps.size() == 0) begin
				$error("unexpected response result_entry=%0d new_tail=%0d",
					rsp.result_entry, rsp.new_tail);
				errors++;
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.result_entry !== want.result_entry) begin
					$error("result_entry expected %0d actual %0d",
						want.result_entry, rsp.result_entry);
					errors++;
				end
				if (rsp.new_tail !== want.new_tail) begin
					$error("new_tail expected %0d actual %0d",
						want.new_tail, rsp.new_tail);
					errors++;
				end
			end
		end
	end

	// Stimulus.
	initial begin
		logic [IDX_W-1:0]  e, t;
		int                k;
		peq_pkg::peq_cmd_t c;
		peq_pkg::peq_rsp_t r;
		arst_n = 1'b0;
		pool_reset();
		for (int i = 0; i < 4; i++) user_tail[i] = NIL;

		// Directed: the extremes, every operation and the corner cases.
		void'(send_cmd(make_cmd(peq_pkg::OP_HEAD, NIL, NIL, '0)));
		void'(send_cmd(make_cmd(peq_pkg::OP_HEAD, 6'd31, 6'd63, 5'd31)));
		void'(send_cmd(make_cmd(peq_pkg::OP_ALLOC, 6'd63, 6'd0, 5'd0)));
		void'(send_cmd(make_cmd(peq_pkg::OP_ALLOC, 6'd0, 6'd0, 5'd0)));
		void'(send_cmd(make_cmd(peq_pkg::OP_ENQ, NIL, 6'd0, 5'd0)));
		void'(send_cmd(make_cmd(peq_pkg::OP_ENQ, 6'd0, 6'd1, 5'd0)));
		void'(send_cmd(make_cmd(peq_pkg::OP_REMOVE, 6'd1, 6'd5, 5'd0)));
		void'(send_cmd(make_cmd(peq_pkg::OP_REMOVE, 6'd1, 6'd1, 5'd0)));
		void'(send_cmd(make_cmd(peq_pkg::OP_DEQ, 6'd0, 6'd0, 5'd0)));
		void'(send_cmd(make_cmd(peq_pkg::OP_DEQ, NIL, 6'd0, 5'd0)));
		void'(send_cmd(make_cmd(peq_pkg::OP_ADD_CH, 6'd40, 6'd0, 5'd31)));
		void'(send_cmd(make_cmd(peq_pkg::OP_ADD_CH, NIL, 6'd1, 5'd31)));
		void'(send_cmd(make_cmd(peq_pkg::OP_ADD_CH, NIL, 6'd2, 5'd31)));
		void'(send_cmd(make_cmd(peq_pkg::OP_ADD_CH, NIL, NIL, 5'd31)));
		void'(send_cmd(make_cmd(peq_pkg::OP_DETACH, NIL, 6'd1, 5'd0)));
		void'(send_cmd(make_cmd(peq_pkg::OP_DETACH, NIL, 6'd1, 5'd0)));
		void'(send_cmd(make_cmd(peq_pkg::OP_REM_FC, NIL, 6'd31, 5'd0)));
		void'(send_cmd(make_cmd(peq_pkg::OP_REM_FC, NIL, 6'd31, 5'd0)));
		void'(send_cmd(make_cmd(peq_pkg::OP_REM_FC, NIL, 6'd31, 5'd0)));
		void'(send_cmd(make_cmd(peq_pkg::OP_FREE, NIL, 6'd0, 5'd0)));
		void'(send_cmd(make_cmd(peq_pkg::OP_FREE, NIL, NIL, 5'd0)));
		void'(send_cmd(make_cmd(4'd9, 6'd3, 6'd3, 5'd3)));
		void'(send_cmd(make_cmd(4'd15, 6'd63, 6'd63, 5'd31)));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Random: mostly well-formed use of a few queues and the tree.
		for (int n = 0; n < 400; n++) begin
			if (n == 200) begin
				// Let every outstanding result come back before going on.
				while (expected_rsps.size() != 0) @(posedge clk);
			end
			k = $urandom_range(0, 3);
			t = user_tail[k];
			case ($urandom_range(0, 19))
				0, 1, 2: e = 6'd0;
				default: e = pick_idx();
			endcase
			if ($urandom_range(0, 9) == 0) begin
				void'(send_cmd(make_cmd(4'($urandom), 6'($urandom),
					6'($urandom), 5'($urandom))));
			end else begin
				case ($urandom_range(0, 9))
					0, 1: c = make_cmd(peq_pkg::OP_ALLOC, t, e, 5'($urandom));
					2:    c = make_cmd(peq_pkg::OP_FREE, t, pick_idx(), '0);
					3, 4: c = make_cmd(peq_pkg::OP_ENQ, t, pick_idx(), '0);
					5:    c = make_cmd(peq_pkg::OP_DEQ, t, e, '0);
					6:    c = make_cmd(peq_pkg::OP_REMOVE, t, pick_idx(), '0);
					7:    c = make_cmd(peq_pkg::OP_ADD_CH, t, pick_idx(),
						5'($urandom_range(0, 3)));
					8:    c = make_cmd(peq_pkg::OP_REM_FC, t,
						IDX_W'($urandom_range(0, 4)), '0);
					default: c = make_cmd(($urandom_range(0, 1) != 0)
						? peq_pkg::OP_DETACH : peq_pkg::OP_HEAD, t, pick_idx(), '0);
				endcase
				// The predicted new tail keeps the queue handle current.
				r = send_cmd(c);
				user_tail[k] = r.new_tail;
			end
		end
		stim_done = 1'b1;
	end

	// End of run: drain the expected responses, then report.
	initial begin
		wait (stim_done);
		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (N + 10) @(posedge clk);
		if (errors == 0) begin
			$display("process_entry_pool_queue_tree_unit test passed");
		end else begin
			$display("process_entry_pool_queue_tree_unit test failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("process_entry_pool_queue_tree_unit test failed");
		$finish;
	end

endmodule
